// ===== rtl/swts_pkg.sv =====
// Shared types, constants and helper functions of the sliding window trend statistics block.
`default_nettype none

package swts_pkg;

  // Widths fixed by the port fields.
  localparam int WINDOW_BITS = 4;
  localparam int FIELD_BITS  = 32;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 4'd7;
  localparam logic [63:0] SAT_U32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] SAT_S32 = 64'h0000_0000_7FFF_FFFF;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MS_SQ   = 2'd0,
    MS_CS2  = 2'd1,
    MS_S1S1 = 2'd2
  } mul_sel_t;

  // Operand selection of the shared divider.
  typedef enum logic [1:0] {
    DS_STD    = 2'd0,
    DS_GROWTH = 2'd1,
    DS_PCT    = 2'd2
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     rd;
    logic     acc;
    logic     step_k;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     sq_add;
    logic     m_load;
    logic     m_sub;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_store;
    logic     pct_direct;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic need_sq;
    logic last_k;
    logic sqrt_last;
    logic trend_ok;
    logic old_zero;
  } sts_t;

  // Unsigned saturation to 32 bits.
  function automatic logic [FIELD_BITS-1:0] sat_u32(input logic [63:0] v);
    logic [63:0] r;
    r = (v > SAT_U32) ? SAT_U32 : v;
    return r[FIELD_BITS-1:0];
  endfunction

  // Magnitude saturated to the positive signed range, then signed.
  function automatic logic [FIELD_BITS-1:0] sat_pct(input logic [63:0] v, input logic neg);
    logic [63:0] r;
    r = (v > SAT_S32) ? SAT_S32 : v;
    if (neg) begin
      r = 64'd0 - r;
    end
    return r[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/swts_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, early finish when done.
`default_nettype none

module swts_mul #(
  parameter int AW = 108,
  parameter int BW = 54
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [AW-1:0] a_in,
  input  wire logic [BW-1:0] b_in,
  output logic               done,
  output logic [AW-1:0]      product
);

  logic          busy;
  logic [AW-1:0] a;
  logic [BW-1:0] b;

  // Control: busy until the multiplier operand runs out of set bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (b == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: add the shifted multiplicand for every set bit.
  always_ff @(posedge clk) begin
    if (start) begin
      a       <= a_in;
      b       <= b_in;
      product <= '0;
    end else if (busy && (b != '0)) begin
      if (b[0]) begin
        product <= product + a;
      end
      a <= a << 1;
      b <= b >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swts_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module swts_div #(
  parameter int DW = 41
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [DW-1:0]      quo
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW-1:0] dsr;
  logic [DW:0]   rem_sh;

  assign rem_sh = {rem[DW-1:0], quo[DW-1]};

  // Control: DW steps after start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dsr}) begin
        rem <= rem_sh - {1'b0, dsr};
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swts_dp.sv =====
// Datapath: sample ring, window walk accumulators, square root and result registers.
`default_nettype none

module swts_dp #(
  parameter int MAX_WINDOW  = 15,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire swts_pkg::cmd_t                       cmd,
  output swts_pkg::sts_t                            sts,
  input  wire logic                                 cfg_we,
  input  wire logic [swts_pkg::WINDOW_BITS-1:0]     cfg_window,
  input  wire logic [swts_pkg::FIELD_BITS-1:0]      new_sample,
  output logic [swts_pkg::FIELD_BITS-1:0]           growth_avg,
  output logic signed [swts_pkg::FIELD_BITS-1:0]    percent_change,
  output logic [swts_pkg::FIELD_BITS-1:0]           std_dev,
  output logic                                      trend_valid
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int RB    = SB + 6;
  localparam int MW    = 2 * RB;
  localparam int DW    = SB + 9;
  localparam int SQW   = $clog2(RB);
  localparam int FB    = swts_pkg::FIELD_BITS;

  logic [SB-1:0]   ring [DEPTH];
  logic [PW-1:0]   wp;
  logic [CNTW-1:0] count;
  logic [swts_pkg::WINDOW_BITS-1:0] win_raw;
  logic [PW-1:0]   w_clamp;
  logic [PW-1:0]   w;
  logic [CNTW-1:0] c;
  logic            ok;
  logic [PW-1:0]   k;
  logic [PW:0]     addr_sum;
  logic [PW-1:0]   addr;
  logic [SB-1:0]   rdata;
  logic [SB-1:0]   prev;
  logic [SB-1:0]   nw;
  logic [SB-1:0]   old;
  logic [RB-1:0]   s1;
  logic [MW-1:0]   s2;
  logic [RB-1:0]   gsum;
  logic [MW-1:0]   m;
  logic [MW-1:0]   sq_op;
  logic [MW-1:0]   sq_res;
  logic [MW-1:0]   sq_one;
  logic [MW-1:0]   sq_sum;
  logic [SQW-1:0]  sq_cnt;
  logic [FB-1:0]   growth_r;
  logic [FB-1:0]   pct_r;
  logic [FB-1:0]   std_r;
  logic [CNTW-1:0] count_next;
  logic [SB-1:0]   sample;
  logic            neg;
  logic [SB-1:0]   mag;
  logic [DW-1:0]   pct_num;
  logic [DW-1:0]   direct_q;
  logic [MW-1:0]   mul_a;
  logic [RB-1:0]   mul_b;
  logic            mul_done;
  logic [MW-1:0]   product;
  logic [DW-1:0]   div_num;
  logic [DW-1:0]   div_den;
  logic            div_done;
  logic [DW-1:0]   div_q;

  assign sample = SB'(new_sample);

  // Effective window: zero acts as one, large values clamp to MAX_WINDOW.
  always_comb begin
    if (win_raw == '0) begin
      w_clamp = PW'(1);
    end else if (int'(win_raw) > MAX_WINDOW) begin
      w_clamp = PW'(MAX_WINDOW);
    end else begin
      w_clamp = PW'(win_raw);
    end
  end

  assign count_next = (count < CNTW'(DEPTH)) ? count + 1'b1 : count;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_raw <= swts_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      win_raw <= cfg_window;
    end
  end

  // Ring pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      count <= '0;
    end else if (cmd.load) begin
      wp    <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      count <= count_next;
    end
  end

  // Ring memory: one write per beat, one registered read per walk step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[wp] <= sample;
    end
  end

  assign addr_sum = (PW + 1)'(wp) + (PW + 1)'(DEPTH - 1) - (PW + 1)'(k);
  assign addr     = (addr_sum >= (PW + 1)'(DEPTH)) ? PW'(addr_sum - (PW + 1)'(DEPTH))
                                                   : PW'(addr_sum);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= ring[addr];
    end
  end

  // Per-item window length, element count and trend flag.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w  <= w_clamp;
      c  <= (count_next < CNTW'(w_clamp)) ? count_next : CNTW'(w_clamp);
      ok <= count_next > CNTW'(w_clamp);
    end
  end

  // Walk index, newest first.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k <= '0;
    end else if (cmd.step_k) begin
      k <= k + 1'b1;
    end
  end

  // Walk accumulators: sum, sum of squares and positive increases, plus the newest and oldest sample.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s1   <= '0;
      s2   <= '0;
      gsum <= '0;
    end else begin
      if (cmd.acc) begin
        if (k == '0) begin
          nw <= rdata;
        end
        if (k == w) begin
          old <= rdata;
        end
        if ((k != '0) && (prev > rdata)) begin
          gsum <= gsum + RB'(prev - rdata);
        end
        prev <= rdata;
        if (sts.need_sq) begin
          s1 <= s1 + RB'(rdata);
        end
      end
      if (cmd.sq_add) begin
        s2 <= s2 + product;
      end
    end
  end

  // Multiplier operands.
  always_comb begin
    case (cmd.mul_sel)
      swts_pkg::MS_SQ: begin
        mul_a = MW'(rdata);
        mul_b = RB'(rdata);
      end
      swts_pkg::MS_CS2: begin
        mul_a = s2;
        mul_b = RB'(c);
      end
      swts_pkg::MS_S1S1: begin
        mul_a = MW'(s1);
        mul_b = s1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  swts_mul #(
    .AW (MW),
    .BW (RB)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .done    (mul_done),
    .product (product)
  );

  // Variance numerator c*S2 - S1*S1.
  always_ff @(posedge clk) begin
    if (cmd.m_load) begin
      m <= product;
    end else if (cmd.m_sub) begin
      m <= m - product;
    end
  end

  // Integer square root, two radicand bits per step.
  assign sq_sum = sq_res + sq_one;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_op  <= m;
      sq_res <= '0;
      sq_one <= MW'(1) << (MW - 2);
      sq_cnt <= '0;
    end else if (cmd.sqrt_step) begin
      if (sq_op >= sq_sum) begin
        sq_op  <= sq_op - sq_sum;
        sq_res <= (sq_res >> 1) + sq_one;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_one <= sq_one >> 2;
      sq_cnt <= sq_cnt + 1'b1;
    end
  end

  // Percent change terms.
  assign neg      = nw < old;
  assign mag      = neg ? old - nw : nw - old;
  assign pct_num  = (DW'(mag) << 7) + (DW'(mag) << 6) + (DW'(mag) << 3) + DW'(old);
  assign direct_q = ((DW'(nw) << 6) + (DW'(nw) << 5) + (DW'(nw) << 2) + DW'(128)) >> 8;

  // Divider operands.
  always_comb begin
    case (cmd.div_sel)
      swts_pkg::DS_STD: begin
        div_num = DW'(sq_res[RB-1:0]);
        div_den = DW'(c);
      end
      swts_pkg::DS_GROWTH: begin
        div_num = DW'(gsum);
        div_den = DW'(w);
      end
      swts_pkg::DS_PCT: begin
        div_num = pct_num;
        div_den = DW'(old) << 1;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  swts_div #(
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  // Result registers of the current item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      growth_r <= '0;
      pct_r    <= '0;
    end else if (cmd.div_store) begin
      case (cmd.div_sel)
        swts_pkg::DS_STD:    std_r    <= swts_pkg::sat_u32(64'(div_q));
        swts_pkg::DS_GROWTH: growth_r <= swts_pkg::sat_u32(64'(div_q));
        swts_pkg::DS_PCT:    pct_r    <= swts_pkg::sat_pct(64'(div_q), neg);
        default:             std_r    <= std_r;
      endcase
    end else if (cmd.pct_direct) begin
      pct_r <= swts_pkg::sat_pct(64'(direct_q), 1'b0);
    end
  end

  // Output register, held until the result beat is taken.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      growth_avg     <= growth_r;
      percent_change <= pct_r;
      std_dev        <= std_r;
      trend_valid    <= ok;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.mul_done  = mul_done;
    sts.div_done  = div_done;
    sts.need_sq   = CNTW'(k) < c;
    sts.last_k    = k == w;
    sts.sqrt_last = sq_cnt == SQW'(RB - 1);
    sts.trend_ok  = ok;
    sts.old_zero  = old == '0;
  end

endmodule

`default_nettype wire

// ===== rtl/swts_ctrl.sv =====
// Controller: sequences the window walk, multiplies, square root and divisions per item.
`default_nettype none

module swts_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output swts_pkg::cmd_t      cmd,
  input  wire swts_pkg::sts_t sts
);

  typedef enum logic [17:0] {
    ST_IDLE      = 18'b000000000000000001,
    ST_RD        = 18'b000000000000000010,
    ST_ACC       = 18'b000000000000000100,
    ST_SQ_WAIT   = 18'b000000000000001000,
    ST_M1_GO     = 18'b000000000000010000,
    ST_M1_WAIT   = 18'b000000000000100000,
    ST_M2_GO     = 18'b000000000001000000,
    ST_M2_WAIT   = 18'b000000000010000000,
    ST_SQRT_INIT = 18'b000000000100000000,
    ST_SQRT      = 18'b000000001000000000,
    ST_DSTD_GO   = 18'b000000010000000000,
    ST_DSTD_WAIT = 18'b000000100000000000,
    ST_DGR_GO    = 18'b000001000000000000,
    ST_DGR_WAIT  = 18'b000010000000000000,
    ST_PZERO     = 18'b000100000000000000,
    ST_DPCT_GO   = 18'b001000000000000000,
    ST_DPCT_WAIT = 18'b010000000000000000,
    ST_DONE      = 18'b100000000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = swts_pkg::MS_SQ;
    cmd.div_sel = swts_pkg::DS_STD;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.need_sq) begin
          cmd.mul_start = 1'b1;
          state_next    = ST_SQ_WAIT;
        end else if (sts.last_k) begin
          state_next = ST_M1_GO;
        end else begin
          cmd.step_k = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_SQ_WAIT: begin
        if (sts.mul_done) begin
          cmd.sq_add = 1'b1;
          if (sts.last_k) begin
            state_next = ST_M1_GO;
          end else begin
            cmd.step_k = 1'b1;
            state_next = ST_RD;
          end
        end
      end
      ST_M1_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = swts_pkg::MS_CS2;
        state_next    = ST_M1_WAIT;
      end
      ST_M1_WAIT: begin
        if (sts.mul_done) begin
          cmd.m_load = 1'b1;
          state_next = ST_M2_GO;
        end
      end
      ST_M2_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = swts_pkg::MS_S1S1;
        state_next    = ST_M2_WAIT;
      end
      ST_M2_WAIT: begin
        if (sts.mul_done) begin
          cmd.m_sub  = 1'b1;
          state_next = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) begin
          state_next = ST_DSTD_GO;
        end
      end
      ST_DSTD_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DSTD_WAIT;
      end
      ST_DSTD_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = sts.trend_ok ? ST_DGR_GO : ST_DONE;
        end
      end
      ST_DGR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = swts_pkg::DS_GROWTH;
        state_next    = ST_DGR_WAIT;
      end
      ST_DGR_WAIT: begin
        cmd.div_sel = swts_pkg::DS_GROWTH;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = sts.old_zero ? ST_PZERO : ST_DPCT_GO;
        end
      end
      ST_PZERO: begin
        cmd.pct_direct = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DPCT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = swts_pkg::DS_PCT;
        state_next    = ST_DPCT_WAIT;
      end
      ST_DPCT_WAIT: begin
        cmd.div_sel = swts_pkg::DS_PCT;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result beat flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten while waiting");

  // An accepted input beat always starts the window walk.
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_RD))
    else $error("accepted beat did not start the walk");

  // The multiplier cannot report done in the cycle right after a start.
  a_mul_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> !sts.mul_done)
    else $error("multiplier done too early");

  // A divider result is only stored in a state that waits for it.
  a_div_store: assert property (@(posedge clk) disable iff (rst)
    cmd.div_store |-> sts.div_done)
    else $error("divider result stored without done");

endmodule

`default_nettype wire

// ===== rtl/sliding_window_trend_stats_core.sv =====
// Top level of the sliding window trend statistics block.
//
//   channel   signals                               direction  meaning
//   input     in_valid/in_ready, new_sample         in         one sample per beat
//   result    out_valid/out_ready, growth_avg,      out        one result beat per sample
//             percent_change, std_dev, trend_valid
//   config    cfg_valid/cfg_ready, cfg_data         in         window length register
//
// One item at a time. An item takes the window walk (each square is a bit-serial multiply),
// two further bit-serial multiplies, SAMPLE_BITS + 6 square root steps and up to three
// divisions. All multiplies share one multiplier and all divisions one divider. Reset
// clears the pointer, fill count, window register (to 7) and the controller; the ring
// needs no clearing. A stalled result waits in the output register; the next sample is
// taken once the result is loaded there.
`default_nettype none

module sliding_window_trend_stats_core #(
  parameter int MAX_WINDOW  = 15,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic [swts_pkg::FIELD_BITS-1:0]          new_sample,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic [swts_pkg::FIELD_BITS-1:0]               growth_avg,
  output logic signed [swts_pkg::FIELD_BITS-1:0]        percent_change,
  output logic [swts_pkg::FIELD_BITS-1:0]               std_dev,
  output logic                                          trend_valid,
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [swts_pkg::WINDOW_BITS-1:0]         cfg_data
);

  swts_pkg::cmd_t cmd;
  swts_pkg::sts_t sts;

  // The window register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  swts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  swts_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_window     (cfg_data),
    .new_sample     (new_sample),
    .growth_avg     (growth_avg),
    .percent_change (percent_change),
    .std_dev        (std_dev),
    .trend_valid    (trend_valid)
  );

endmodule

`default_nettype wire
